>>> sv/bwc_pkg.sv
// shared types and constants for the bmp window crop block
package bwc_pkg;

    // default for the largest source dimension handled
    localparam int MAX_DIMENSION_DEF = 4096;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // field widths fixed by the register map
    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 3;

    // register indexes of the configuration port
    typedef enum logic [INDEX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_WINDOW_LEFT   = 3'd2,
        CFG_WINDOW_TOP    = 3'd3,
        CFG_WINDOW_WIDTH  = 3'd4,
        CFG_WINDOW_HEIGHT = 3'd5
    } t_cfg_index;

    // configuration register set
    typedef struct packed {
        logic [DIM_W-1:0] source_width;
        logic [DIM_W-1:0] source_height;
        logic [POS_W-1:0] window_left;
        logic [POS_W-1:0] window_top;
        logic [DIM_W-1:0] window_width;
        logic [DIM_W-1:0] window_height;
    } t_crop_cfg;

    // one kept pixel with what the back end needs to expand it
    typedef struct packed {
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte2;
        logic [1:0]        pads;
        logic              last_col;
        logic              top_row;
    } t_crop_job;

    // front to queue push request
    typedef struct packed {
        logic      push;
        t_crop_job job;
    } t_queue_push;

    // queue to back head view
    typedef struct packed {
        logic      not_empty;
        t_crop_job job;
    } t_queue_head;

endpackage

>>> sv/bwc_front.sv
// front end: pixel acceptance, position tracking and window classification
module bwc_front #(
    parameter int MAX_DIMENSION = bwc_pkg::MAX_DIMENSION_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bwc_pkg::t_crop_cfg        i_cfg,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [bwc_pkg::BYTE_W-1:0] i_pixel_byte0,
    input  logic [bwc_pkg::BYTE_W-1:0] i_pixel_byte1,
    input  logic [bwc_pkg::BYTE_W-1:0] i_pixel_byte2,
    input  logic                      i_queue_full,
    output bwc_pkg::t_queue_push      o_push
);
    import bwc_pkg::*;

    // counter width and a compare width that holds every sum involved
    localparam int CW   = $clog2(MAX_DIMENSION);
    localparam int SUMW = POS_W + 2;
    localparam int XW   = (CW + 1 > SUMW) ? CW + 1 : SUMW;
    localparam logic [XW-1:0] MAX_X = XW'(MAX_DIMENSION);
    localparam logic [CW:0]   MAX_D = (CW + 1)'(MAX_DIMENSION);

    logic [CW-1:0] r_col,  n_col;
    logic [CW-1:0] r_srow, n_srow;

    logic [CW:0]   w_eff, h_eff;
    logic [CW-1:0] col, srow, irow;
    logic [XW-1:0] col_x, irow_x, left_x, top_x, lend_x, tend_x;
    logic          in_cols, in_rows, last_col, top_row, accept;

    // clamp source dimensions to one through the maximum
    always_comb begin
        priority if (i_cfg.source_width == '0) begin
            w_eff = (CW + 1)'(1);
        end else if (XW'(i_cfg.source_width) > MAX_X) begin
            w_eff = MAX_D;
        end else begin
            w_eff = (CW + 1)'(i_cfg.source_width);
        end
        priority if (i_cfg.source_height == '0) begin
            h_eff = (CW + 1)'(1);
        end else if (XW'(i_cfg.source_height) > MAX_X) begin
            h_eff = MAX_D;
        end else begin
            h_eff = (CW + 1)'(i_cfg.source_height);
        end
    end

    // current position, clamped to the image, and its image row
    always_comb begin
        col  = ({1'b0, r_col}  >= w_eff) ? CW'(w_eff - 1'b1) : r_col;
        srow = ({1'b0, r_srow} >= h_eff) ? CW'(h_eff - 1'b1) : r_srow;
        irow = CW'(h_eff - 1'b1 - {1'b0, srow});
    end

    // window test
    always_comb begin
        col_x    = XW'(col);
        irow_x   = XW'(irow);
        left_x   = XW'(i_cfg.window_left);
        top_x    = XW'(i_cfg.window_top);
        lend_x   = left_x + XW'(i_cfg.window_width);
        tend_x   = top_x + XW'(i_cfg.window_height);
        in_cols  = (col_x >= left_x) && (col_x < lend_x);
        in_rows  = (irow_x >= top_x) && (irow_x < tend_x);
        last_col = (col_x == lend_x - 1'b1);
        top_row  = (irow_x == top_x);
    end

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    // job for the back end, only for pixels inside the window
    always_comb begin
        o_push.push         = accept && in_cols && in_rows;
        o_push.job.byte0    = i_pixel_byte0;
        o_push.job.byte1    = i_pixel_byte1;
        o_push.job.byte2    = i_pixel_byte2;
        o_push.job.pads     = last_col ? i_cfg.window_width[1:0] : 2'd0;
        o_push.job.last_col = last_col;
        o_push.job.top_row  = top_row;
    end

    // next position, wrapping at row and image end
    always_comb begin
        n_col  = r_col;
        n_srow = r_srow;
        if (accept) begin
            if (({1'b0, col} + 1'b1) >= w_eff) begin
                n_col  = '0;
                n_srow = (({1'b0, srow} + 1'b1) >= h_eff) ? '0 : srow + 1'b1;
            end else begin
                n_col  = col + 1'b1;
                n_srow = srow;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_srow <= '0;
        end else begin
            r_col  <= n_col;
            r_srow <= n_srow;
        end
    end

endmodule

>>> sv/bwc_queue.sv
// short job queue between front and back ends
module bwc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bwc_pkg::t_queue_push i_push,
    output logic                 o_full,
    input  logic                 i_pop,
    output bwc_pkg::t_queue_head o_head
);
    import bwc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_crop_job     r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PW:0]   r_count,  n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == (PW + 1)'(QUEUE_DEPTH));
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    // head of the queue
    always_comb begin
        o_head.not_empty = (r_count != '0);
        o_head.job       = r_mem[r_rd_ptr];
    end

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

endmodule

>>> sv/bwc_back.sv
// back end: expands each job into pixel and padding beats
module bwc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bwc_pkg::t_queue_head       i_head,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bwc_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_is_padding,
    output logic                       o_row_end,
    output logic                       o_image_end
);
    import bwc_pkg::*;

    logic [2:0]        r_idx, n_idx;
    logic              r_valid, n_valid;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_pad, n_pad;
    logic              r_rend, n_rend;
    logic              r_iend, n_iend;
    logic [2:0]        last_idx;
    logic              load, is_last;

    // output slot is free or its beat is taken this cycle
    assign load     = i_head.not_empty && (!r_valid || !i_stall);
    assign last_idx = 3'd2 + {1'b0, i_head.job.pads};
    assign is_last  = (r_idx == last_idx);
    assign o_pop    = load && is_last;

    // select the next beat of the head job
    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid && i_stall;
        n_byte  = r_byte;
        n_pad   = r_pad;
        n_rend  = r_rend;
        n_iend  = r_iend;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = is_last ? 3'd0 : r_idx + 1'b1;
            n_pad   = (r_idx > 3'd2);
            n_rend  = is_last && i_head.job.last_col;
            n_iend  = is_last && i_head.job.last_col && i_head.job.top_row;
            unique case (r_idx)
                3'd0:    n_byte = i_head.job.byte0;
                3'd1:    n_byte = i_head.job.byte1;
                3'd2:    n_byte = i_head.job.byte2;
                default: n_byte = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_pad  <= n_pad;
        r_rend <= n_rend;
        r_iend <= n_iend;
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_byte;
    assign o_is_padding = r_pad;
    assign o_row_end    = r_rend;
    assign o_image_end  = r_iend;

endmodule

>>> sv/bmp_window_crop.sv
// top level of the bmp window crop block: register file, front, queue and back
//
//  channel   direction  handshake               payload
//  pixel     in         i_valid / o_stall       i_pixel_byte0..2
//  byte      out        o_valid / i_stall       o_out_byte, o_is_padding, o_row_end,
//                                               o_image_end
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one pixel beat is taken per cycle while the job queue has room; the back end
// emits one byte beat per cycle while i_stall is low, through the single byte port,
// so a kept pixel gives three bytes, or three plus window_width mod 4 at a window
// row end; a pixel outside the window gives none. the first byte beat passes
// through the job queue and the back end output register after its pixel beat
// is taken. reset clears counters, queue and output valid; no clearing pass.
// an output stall fills the queue, after which the input is stalled.
module bmp_window_crop #(
    parameter int MAX_DIMENSION = bwc_pkg::MAX_DIMENSION_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [bwc_pkg::BYTE_W-1:0]  i_pixel_byte0,
    input  logic [bwc_pkg::BYTE_W-1:0]  i_pixel_byte1,
    input  logic [bwc_pkg::BYTE_W-1:0]  i_pixel_byte2,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bwc_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_is_padding,
    output logic                        o_row_end,
    output logic                        o_image_end,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bwc_pkg::INDEX_W-1:0] i_cfg_index,
    input  logic [bwc_pkg::DIM_W-1:0]   i_cfg_data
);
    import bwc_pkg::*;

    t_crop_cfg   r_cfg, n_cfg;
    t_queue_push push;
    t_queue_head head;
    logic        queue_full, pop;

    assign o_cfg_ready = 1'b1;

    // register writes; unknown indexes are ignored
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SOURCE_WIDTH:  n_cfg.source_width  = i_cfg_data;
                CFG_SOURCE_HEIGHT: n_cfg.source_height = i_cfg_data;
                CFG_WINDOW_LEFT:   n_cfg.window_left   = i_cfg_data[POS_W-1:0];
                CFG_WINDOW_TOP:    n_cfg.window_top    = i_cfg_data[POS_W-1:0];
                CFG_WINDOW_WIDTH:  n_cfg.window_width  = i_cfg_data;
                CFG_WINDOW_HEIGHT: n_cfg.window_height = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_width  <= DIM_W'(1);
            r_cfg.source_height <= DIM_W'(1);
            r_cfg.window_left   <= '0;
            r_cfg.window_top    <= '0;
            r_cfg.window_width  <= DIM_W'(1);
            r_cfg.window_height <= DIM_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // classification of incoming pixels
    bwc_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_byte0 (i_pixel_byte0),
        .i_pixel_byte1 (i_pixel_byte1),
        .i_pixel_byte2 (i_pixel_byte2),
        .i_queue_full  (queue_full),
        .o_push        (push)
    );

    // decoupling queue
    bwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    // byte expansion
    bwc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_is_padding (o_is_padding),
        .o_row_end    (o_row_end),
        .o_image_end  (o_image_end)
    );

endmodule
